### sv/scc_pkg.sv
// Shared types and constants for the simplex cell checker.
// No dependencies; imported by simplex_cell_checker.
package scc_pkg;

	// default coordinate width, two's complement
	localparam int COORD_BITS_DEF = 24;
	// width of the running cell number
	localparam int INDEX_BITS = 32;

	// cell kind register codes
	typedef enum logic [0:0] {
		KIND_TRI = 1'b0,
		KIND_TET = 1'b1
	} cell_kind_t;

endpackage

### sv/simplex_cell_checker.sv
// Simplex cell checker top level: six-stage orientation and diagonal pipeline.
// Depends on scc_pkg (cell kind codes, index width, default coordinate width).
//
// Checks one mesh cell per request, given as four vertices a, b, c, d in signed
// fixed point, and returns one result per request: the running cell number,
// a flag for negative orientation and a flag for a bad internal diagonal.
// cell_kind = KIND_TRI takes the x and y of a, b and c and flags a negative
// signed area; bad_diagonal is then always 0. cell_kind = KIND_TET flags a
// negative edge-vector determinant (six times the volume) and flags the cell
// when the squared midpoint distance of the ac-bd edge pair exceeds that of
// the smaller of the ab-cd and ad-bc pairs (a tie is not flagged). All
// arithmetic is exact; a zero area or volume is not flagged. Write cell_kind
// only while the block is empty. The cell number starts at 0 after reset and
// wraps at 2^32.
// Throughput is one cell per clock while out_ready is high. The stage count
// is set by the determinant path: edge products, 2x2 minors, minor-by-edge
// partial products (each minor split in two halves to keep every multiplier
// near 32 x 32), partial product assembly, and the final three-term sum.
// Each stage holds its own valid bit and takes a new request whenever it is
// empty or its content moves on, so bubbles close up and a request is
// accepted while a finished result waits at the output register, as long
// as some stage is empty.

module simplex_cell_checker #(
	parameter int COORD_BITS = scc_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic                            cfg_wdata,
	// request channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [COORD_BITS-1:0]    ax,
	input  logic signed [COORD_BITS-1:0]    ay,
	input  logic signed [COORD_BITS-1:0]    az,
	input  logic signed [COORD_BITS-1:0]    bx,
	input  logic signed [COORD_BITS-1:0]    by,
	input  logic signed [COORD_BITS-1:0]    bz,
	input  logic signed [COORD_BITS-1:0]    cx,
	input  logic signed [COORD_BITS-1:0]    cy,
	input  logic signed [COORD_BITS-1:0]    cz,
	input  logic signed [COORD_BITS-1:0]    dx,
	input  logic signed [COORD_BITS-1:0]    dy,
	input  logic signed [COORD_BITS-1:0]    dz,
	// result channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [scc_pkg::INDEX_BITS-1:0]  cell_index,
	output logic                            negative_orientation,
	output logic                            bad_diagonal
);

	import scc_pkg::*;

	// widths
	localparam int D  = COORD_BITS + 1;      // edge vector component
	localparam int D2 = 2 * D;               // edge product
	localparam int M  = 2 * COORD_BITS + 3;  // 2x2 minor, also area
	localparam int LO = COORD_BITS + 2;      // low half of a minor
	localparam int PL = D + LO + 1;          // edge times low half
	localparam int T  = 3 * COORD_BITS + 4;  // triple product term and determinant
	localparam int P  = COORD_BITS + 3;      // midpoint pair sum
	localparam int Q  = 2 * COORD_BITS + 2;  // pair square, unsigned
	localparam int L  = 2 * COORD_BITS + 4;  // sum of three squares, unsigned
	localparam int NS = 6;                   // pipeline depth

	// ---------------------------------------------------------------
	// control: cell kind register, cell counter, stage valid bits
	// ---------------------------------------------------------------
	cell_kind_t              kind_q;
	logic [INDEX_BITS-1:0]   cnt_q;
	logic [NS:1]             vld_q;          // vld_q[k]: stage k holds a cell
	logic [NS+1:1]           en;             // en[k]: stage k loads this cycle
	logic                    take;

	// a stage loads when empty or when its content moves on
	always_comb begin
		en[NS+1] = out_ready;
		for (int k = NS; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign in_ready = en[1];
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_TRI;
			cnt_q  <= '0;
			vld_q  <= '0;
		end else begin
			if (cfg_we) begin
				kind_q <= cell_kind_t'(cfg_wdata);
			end
			if (take) begin
				cnt_q <= cnt_q + INDEX_BITS'(1);
			end
			if (en[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// stage 1: edge vectors from a, midpoint pair sums
	// ---------------------------------------------------------------
	logic signed [D-1:0]     ux_s1, uy_s1, uz_s1;
	logic signed [D-1:0]     vx_s1, vy_s1, vz_s1;
	logic signed [D-1:0]     wx_s1, wy_s1, wz_s1;
	// pair 0: ab-cd, pair 1: ac-bd (middle diagonal), pair 2: ad-bc
	logic signed [P-1:0]     p0x_s1, p0y_s1, p0z_s1;
	logic signed [P-1:0]     p1x_s1, p1y_s1, p1z_s1;
	logic signed [P-1:0]     p2x_s1, p2y_s1, p2z_s1;
	cell_kind_t              kind_s1;
	logic [INDEX_BITS-1:0]   idx_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			ux_s1   <= D'(bx) - D'(ax);
			uy_s1   <= D'(by) - D'(ay);
			uz_s1   <= D'(bz) - D'(az);
			vx_s1   <= D'(cx) - D'(ax);
			vy_s1   <= D'(cy) - D'(ay);
			vz_s1   <= D'(cz) - D'(az);
			wx_s1   <= D'(dx) - D'(ax);
			wy_s1   <= D'(dy) - D'(ay);
			wz_s1   <= D'(dz) - D'(az);
			p0x_s1  <= P'(cx) + P'(dx) - P'(ax) - P'(bx);
			p0y_s1  <= P'(cy) + P'(dy) - P'(ay) - P'(by);
			p0z_s1  <= P'(cz) + P'(dz) - P'(az) - P'(bz);
			p1x_s1  <= P'(bx) + P'(dx) - P'(ax) - P'(cx);
			p1y_s1  <= P'(by) + P'(dy) - P'(ay) - P'(cy);
			p1z_s1  <= P'(bz) + P'(dz) - P'(az) - P'(cz);
			p2x_s1  <= P'(bx) + P'(cx) - P'(ax) - P'(dx);
			p2y_s1  <= P'(by) + P'(cy) - P'(ay) - P'(dy);
			p2z_s1  <= P'(bz) + P'(cz) - P'(az) - P'(dz);
			kind_s1 <= kind_q;
			idx_s1  <= cnt_q;
		end
	end

	// ---------------------------------------------------------------
	// stage 2: edge products for minors and area, pair squares
	// ---------------------------------------------------------------
	logic signed [D2-1:0]    mxa_s2, mxb_s2, mya_s2, myb_s2, mza_s2, mzb_s2;
	logic signed [D2-1:0]    ara_s2, arb_s2;
	logic signed [D-1:0]     ux_s2, uy_s2, uz_s2;
	logic [Q-1:0]            sq0x_s2, sq0y_s2, sq0z_s2;
	logic [Q-1:0]            sq1x_s2, sq1y_s2, sq1z_s2;
	logic [Q-1:0]            sq2x_s2, sq2y_s2, sq2z_s2;
	cell_kind_t              kind_s2;
	logic [INDEX_BITS-1:0]   idx_s2;

	// a pair sum stays below 2^(COORD_BITS+1) in size, so its square fits Q bits
	function automatic logic [Q-1:0] pair_sq(input logic signed [P-1:0] s);
		logic signed [2*P-1:0] full;
		full = (2*P)'(s) * (2*P)'(s);
		return full[Q-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en[2]) begin
			mxa_s2  <= D2'(vy_s1) * D2'(wz_s1);
			mxb_s2  <= D2'(vz_s1) * D2'(wy_s1);
			mya_s2  <= D2'(vx_s1) * D2'(wz_s1);
			myb_s2  <= D2'(vz_s1) * D2'(wx_s1);
			mza_s2  <= D2'(vx_s1) * D2'(wy_s1);
			mzb_s2  <= D2'(vy_s1) * D2'(wx_s1);
			ara_s2  <= D2'(ux_s1) * D2'(vy_s1);
			arb_s2  <= D2'(vx_s1) * D2'(uy_s1);
			sq0x_s2 <= pair_sq(p0x_s1);
			sq0y_s2 <= pair_sq(p0y_s1);
			sq0z_s2 <= pair_sq(p0z_s1);
			sq1x_s2 <= pair_sq(p1x_s1);
			sq1y_s2 <= pair_sq(p1y_s1);
			sq1z_s2 <= pair_sq(p1z_s1);
			sq2x_s2 <= pair_sq(p2x_s1);
			sq2y_s2 <= pair_sq(p2y_s1);
			sq2z_s2 <= pair_sq(p2z_s1);
			ux_s2   <= ux_s1;
			uy_s2   <= uy_s1;
			uz_s2   <= uz_s1;
			kind_s2 <= kind_s1;
			idx_s2  <= idx_s1;
		end
	end

	// ---------------------------------------------------------------
	// stage 3: 2x2 minors, area sign, squared pair distances
	// ---------------------------------------------------------------
	logic signed [M-1:0]     mnx_s3, mny_s3, mnz_s3;
	logic signed [M-1:0]     area;
	logic                    aneg_s3;
	logic [L-1:0]            l0_s3, l1_s3, l2_s3;
	logic signed [D-1:0]     ux_s3, uy_s3, uz_s3;
	cell_kind_t              kind_s3;
	logic [INDEX_BITS-1:0]   idx_s3;

	assign area = M'(ara_s2) - M'(arb_s2);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			mnx_s3  <= M'(mxa_s2) - M'(mxb_s2);
			mny_s3  <= M'(mya_s2) - M'(myb_s2);
			mnz_s3  <= M'(mza_s2) - M'(mzb_s2);
			aneg_s3 <= area[M-1];
			l0_s3   <= L'(sq0x_s2) + L'(sq0y_s2) + L'(sq0z_s2);
			l1_s3   <= L'(sq1x_s2) + L'(sq1y_s2) + L'(sq1z_s2);
			l2_s3   <= L'(sq2x_s2) + L'(sq2y_s2) + L'(sq2z_s2);
			ux_s3   <= ux_s2;
			uy_s3   <= uy_s2;
			uz_s3   <= uz_s2;
			kind_s3 <= kind_s2;
			idx_s3  <= idx_s2;
		end
	end

	// ---------------------------------------------------------------
	// stage 4: edge times minor, split in high and low halves;
	//          diagonal compare
	// ---------------------------------------------------------------
	logic signed [D2-1:0]    phx_s4, phy_s4, phz_s4;
	logic signed [PL-1:0]    plx_s4, ply_s4, plz_s4;
	logic                    aneg_s4, bad_s4;
	cell_kind_t              kind_s4;
	logic [INDEX_BITS-1:0]   idx_s4;

	// low half taken as a positive number
	function automatic logic signed [PL-1:0] mul_lo(input logic signed [D-1:0] e,
			input logic signed [M-1:0] m);
		logic signed [LO:0] lo;
		lo = $signed({1'b0, m[LO-1:0]});
		return PL'(e) * PL'(lo);
	endfunction

	function automatic logic signed [D2-1:0] mul_hi(input logic signed [D-1:0] e,
			input logic signed [M-1:0] m);
		logic signed [M-LO-1:0] hi;
		hi = $signed(m[M-1:LO]);
		return D2'(e) * D2'(hi);
	endfunction

	always_ff @(posedge clk) begin
		if (en[4]) begin
			phx_s4  <= mul_hi(ux_s3, mnx_s3);
			phy_s4  <= mul_hi(uy_s3, mny_s3);
			phz_s4  <= mul_hi(uz_s3, mnz_s3);
			plx_s4  <= mul_lo(ux_s3, mnx_s3);
			ply_s4  <= mul_lo(uy_s3, mny_s3);
			plz_s4  <= mul_lo(uz_s3, mnz_s3);
			// ties with the shortest pair pass
			bad_s4  <= (l0_s3 < l1_s3) || (l2_s3 < l1_s3);
			aneg_s4 <= aneg_s3;
			kind_s4 <= kind_s3;
			idx_s4  <= idx_s3;
		end
	end

	// ---------------------------------------------------------------
	// stage 5: assemble the three cofactor terms
	// ---------------------------------------------------------------
	logic signed [T-1:0]     tx_s5, ty_s5, tz_s5;
	logic                    aneg_s5, bad_s5;
	cell_kind_t              kind_s5;
	logic [INDEX_BITS-1:0]   idx_s5;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			tx_s5   <= (T'(phx_s4) <<< LO) + T'(plx_s4);
			ty_s5   <= (T'(phy_s4) <<< LO) + T'(ply_s4);
			tz_s5   <= (T'(phz_s4) <<< LO) + T'(plz_s4);
			aneg_s5 <= aneg_s4;
			bad_s5  <= bad_s4;
			kind_s5 <= kind_s4;
			idx_s5  <= idx_s4;
		end
	end

	// ---------------------------------------------------------------
	// stage 6: determinant sign, flag select, output register
	// ---------------------------------------------------------------
	logic signed [T-1:0]     det;
	logic                    neg_s6, bad_s6;
	logic [INDEX_BITS-1:0]   idx_s6;

	assign det = tx_s5 - ty_s5 + tz_s5;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			unique case (kind_s5)
				KIND_TRI: begin
					neg_s6 <= aneg_s5;
					bad_s6 <= 1'b0;
				end
				KIND_TET: begin
					neg_s6 <= det[T-1];
					bad_s6 <= bad_s5;
				end
				default: begin
					neg_s6 <= 1'b0;
					bad_s6 <= 1'b0;
				end
			endcase
			idx_s6 <= idx_s5;
		end
	end

	assign out_valid            = vld_q[NS];
	assign cell_index           = idx_s6;
	assign negative_orientation = neg_s6;
	assign bad_diagonal         = bad_s6;

endmodule
